// ----- src/bfs_pkg.sv -----
// Shared constants for the breadth-first shortest path block.
package bfs_pkg;

    localparam int DEF_MAX_NODES = 64;
    localparam int DEF_MAX_EDGES = 256;

    localparam int NODE_W = 6;
    localparam int MODE_W = 2;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 7;

    localparam logic [CNT_W-1:0] NODE_COUNT_RST = 7'd64;

    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_UNREACH = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE   = 2'd3;

endpackage

// ----- src/bfs_in_if.sv -----
// Input channel: one command beat per item.
interface bfs_in_if
    import bfs_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [NODE_W-1:0] from_node;
    logic [NODE_W-1:0] to_node;

    modport source (output valid, mode, from_node, to_node, input ready);
    modport sink   (input valid, mode, from_node, to_node, output ready);
endinterface

// ----- src/bfs_out_if.sv -----
// Output channel: one result beat per path node or status.
interface bfs_out_if
    import bfs_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [NODE_W-1:0] path_node;
    logic              last;
    logic [STAT_W-1:0] status;

    modport source (output valid, path_node, last, status, input ready);
    modport sink   (input valid, path_node, last, status, output ready);
endinterface

// ----- src/bfs_cfg_if.sv -----
// Configuration write channel for the node count register.
interface bfs_cfg_if
    import bfs_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] node_count;

    modport source (output valid, node_count, input ready);
    modport sink   (input valid, node_count, output ready);
endinterface

// ----- src/bfs_shortest_path.sv -----
// Top level of the breadth-first shortest path engine over a stored directed graph.
//
// The block holds a directed graph as one linked edge list per node, in insertion
// order. An add beat appends an edge, or is refused with a range or full status,
// and answers with one status beat from the S_RESP state once the output register
// is free; a clear beat empties the graph when it is accepted and answers with one
// status beat. A query beat runs a breadth-first search from the source and then
// streams the path from source to destination, one beat per node, with last set on
// the final beat; an unreachable destination or a node at or above the node count
// gives a single status beat. Items are handled one at a time. The search pops each
// visited node from the queue, reads its list head and tail, and reads the edge
// memory once per edge followed; the parent walk then stores each path node in the
// path memory, and playback reads each one back from the path memory in turn. The
// next item is taken while the last result beat still waits at the output register.
// The node count register may be written at any time the block is idle; a value of
// zero acts as one and values above MAX_NODES saturate.
module bfs_shortest_path
    import bfs_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES,
    parameter int MAX_EDGES = DEF_MAX_EDGES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bfs_in_if.sink     i_in,
    bfs_out_if.source  o_out,
    bfs_cfg_if.sink    i_cfg
);

    localparam int NW = $clog2(MAX_NODES);
    localparam int EW = $clog2(MAX_EDGES);
    localparam logic [CNT_W-1:0] MAXN = CNT_W'(MAX_NODES);
    localparam logic [EW:0]      MAXE = (EW+1)'(MAX_EDGES);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ADD   = 4'd1;
    localparam logic [3:0] S_RESP  = 4'd2;
    localparam logic [3:0] S_QINIT = 4'd3;
    localparam logic [3:0] S_POP   = 4'd4;
    localparam logic [3:0] S_NODE  = 4'd5;
    localparam logic [3:0] S_HEAD  = 4'd6;
    localparam logic [3:0] S_EDGE  = 4'd7;
    localparam logic [3:0] S_CHK   = 4'd8;
    localparam logic [3:0] S_WALK  = 4'd9;
    localparam logic [3:0] S_ERD   = 4'd10;
    localparam logic [3:0] S_EOUT  = 4'd11;

    // Storage: edge targets and links, list heads and tails, search parents,
    // the visit queue and the path buffer all live in synchronous memories.
    logic [NODE_W-1:0] mem_tgt  [MAX_EDGES];
    logic [EW-1:0]     mem_link [MAX_EDGES];
    logic [EW-1:0]     mem_head [MAX_NODES];
    logic [EW-1:0]     mem_tail [MAX_NODES];
    logic [NODE_W-1:0] mem_par  [MAX_NODES];
    logic [NODE_W-1:0] mem_q    [MAX_NODES];
    logic [NODE_W-1:0] mem_path [MAX_NODES];

    logic [3:0]          r_state, n_state;
    logic [CNT_W-1:0]    r_node_count;
    logic [EW:0]         r_edges_used, n_edges_used;
    logic [MAX_NODES-1:0] r_nonempty, n_nonempty;
    logic [MAX_NODES-1:0] r_seen, n_seen;
    logic [NODE_W-1:0]   r_a, n_a, r_b, n_b, r_node, n_node;
    logic [NW:0]         r_qhead, n_qhead, r_qtail, n_qtail, r_len, n_len;
    logic [NW-1:0]       r_k, n_k;
    logic [EW-1:0]       r_e, n_e, r_etail, n_etail;
    logic [STAT_W-1:0]   r_rstat, n_rstat;
    logic                r_ovalid, n_ovalid, r_olast, n_olast;
    logic [NODE_W-1:0]   r_opath, n_opath;
    logic [STAT_W-1:0]   r_ostat, n_ostat;

    // Registered read data.
    logic [NODE_W-1:0] r_tgt_rd, r_par_rd, r_q_rd, r_path_rd;
    logic [EW-1:0]     r_link_rd, r_head_rd, r_tail_rd;

    // Memory port controls.
    logic              edge_we, link_we, edge_re, head_we, tail_we, ht_re;
    logic              par_we, par_re, q_we, q_re, path_we, path_re;
    logic [EW-1:0]     edge_wa, link_wa, link_wd, edge_ra, head_wd, tail_wd;
    logic [NW-1:0]     ht_wa, ht_ra, par_wa, par_ra, q_wa, q_ra, path_wa, path_ra;
    logic [NODE_W-1:0] edge_wd, par_wd, q_wd, path_wd;

    logic [CNT_W-1:0]  n_act;
    logic              in_acc, can_push, bad_node;
    logic [NODE_W-1:0] t_node;

    always_comb begin
        if (r_node_count == '0) begin
            n_act = CNT_W'(1);
        end else if (r_node_count > MAXN) begin
            n_act = MAXN;
        end else begin
            n_act = r_node_count;
        end
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign in_acc      = i_in.valid && i_in.ready;
    assign can_push    = !r_ovalid || o_out.ready;
    assign bad_node    = ({1'b0, i_in.from_node} >= n_act) || ({1'b0, i_in.to_node} >= n_act);
    assign t_node      = r_tgt_rd;

    assign i_cfg.ready     = 1'b1;
    assign o_out.valid     = r_ovalid;
    assign o_out.path_node = r_opath;
    assign o_out.last      = r_olast;
    assign o_out.status    = r_ostat;

    always_comb begin
        n_state = r_state;      n_edges_used = r_edges_used;
        n_nonempty = r_nonempty; n_seen = r_seen;
        n_a = r_a;  n_b = r_b;  n_node = r_node;
        n_qhead = r_qhead;  n_qtail = r_qtail;  n_len = r_len;  n_k = r_k;
        n_e = r_e;  n_etail = r_etail;  n_rstat = r_rstat;
        n_ovalid = r_ovalid && !o_out.ready;
        n_opath = r_opath;  n_olast = r_olast;  n_ostat = r_ostat;

        edge_we = 1'b0; edge_wa = '0; edge_wd = '0;
        link_we = 1'b0; link_wa = '0; link_wd = '0;
        edge_re = 1'b0; edge_ra = '0;
        head_we = 1'b0; tail_we = 1'b0; ht_wa = '0; head_wd = '0; tail_wd = '0;
        ht_re = 1'b0;   ht_ra = '0;
        par_we = 1'b0;  par_wa = '0; par_wd = '0; par_re = 1'b0; par_ra = '0;
        q_we = 1'b0;    q_wa = '0;   q_wd = '0;   q_re = 1'b0;   q_ra = '0;
        path_we = 1'b0; path_wa = '0; path_wd = '0; path_re = 1'b0; path_ra = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_a = i_in.from_node;
                    n_b = i_in.to_node;
                    unique case (i_in.mode)
                        MODE_ADD: begin
                            if (bad_node) begin
                                n_rstat = ST_RANGE; n_state = S_RESP;
                            end else if (r_edges_used >= MAXE) begin
                                n_rstat = ST_FULL; n_state = S_RESP;
                            end else begin
                                ht_re = 1'b1;
                                ht_ra = i_in.from_node[NW-1:0];
                                n_state = S_ADD;
                            end
                        end
                        MODE_QUERY: begin
                            if (bad_node) begin
                                n_rstat = ST_RANGE; n_state = S_RESP;
                            end else begin
                                n_state = S_QINIT;
                            end
                        end
                        MODE_CLEAR: begin
                            n_nonempty = '0;
                            n_edges_used = '0;
                            n_rstat = ST_OK;
                            n_state = S_RESP;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_ADD: begin
                // Append the new edge behind the current tail of its list, or make it the head of an empty list.
                edge_we = 1'b1;
                edge_wa = r_edges_used[EW-1:0];
                edge_wd = r_b;
                if (r_nonempty[r_a[NW-1:0]]) begin
                    link_we = 1'b1;
                    link_wa = r_tail_rd;
                    link_wd = r_edges_used[EW-1:0];
                end else begin
                    head_we = 1'b1;
                    head_wd = r_edges_used[EW-1:0];
                    n_nonempty[r_a[NW-1:0]] = 1'b1;
                end
                tail_we = 1'b1;
                ht_wa = r_a[NW-1:0];
                tail_wd = r_edges_used[EW-1:0];
                n_edges_used = r_edges_used + 1'b1;
                n_rstat = ST_OK;
                n_state = S_RESP;
            end
            S_RESP: begin
                if (can_push) begin
                    n_ovalid = 1'b1; n_opath = '0; n_olast = 1'b1; n_ostat = r_rstat;
                    n_state = S_IDLE;
                end
            end
            S_QINIT: begin
                n_seen = '0;
                n_seen[r_a[NW-1:0]] = 1'b1;
                q_we = 1'b1; q_wa = '0; q_wd = r_a;
                n_qhead = '0;
                n_qtail = (NW+1)'(1);
                n_state = S_POP;
            end
            S_POP: begin
                if (r_qhead == r_qtail) begin
                    n_state = S_CHK;
                end else begin
                    q_re = 1'b1; q_ra = r_qhead[NW-1:0];
                    n_qhead = r_qhead + 1'b1;
                    n_state = S_NODE;
                end
            end
            S_NODE: begin
                n_node = r_q_rd;
                if (r_nonempty[r_q_rd[NW-1:0]]) begin
                    ht_re = 1'b1; ht_ra = r_q_rd[NW-1:0];
                    n_state = S_HEAD;
                end else begin
                    n_state = S_POP;
                end
            end
            S_HEAD: begin
                n_e = r_head_rd;
                n_etail = r_tail_rd;
                edge_re = 1'b1; edge_ra = r_head_rd;
                n_state = S_EDGE;
            end
            S_EDGE: begin
                if (!r_seen[t_node[NW-1:0]]) begin
                    n_seen[t_node[NW-1:0]] = 1'b1;
                    par_we = 1'b1; par_wa = t_node[NW-1:0]; par_wd = r_node;
                    q_we = 1'b1; q_wa = r_qtail[NW-1:0]; q_wd = t_node;
                    n_qtail = r_qtail + 1'b1;
                end
                if (r_e == r_etail) begin
                    n_state = S_POP;
                end else begin
                    edge_re = 1'b1; edge_ra = r_link_rd;
                    n_e = r_link_rd;
                end
            end
            S_CHK: begin
                if (!r_seen[r_b[NW-1:0]]) begin
                    n_rstat = ST_UNREACH; n_state = S_RESP;
                end else begin
                    path_we = 1'b1; path_wa = '0; path_wd = r_b;
                    n_len = (NW+1)'(1);
                    if (r_b == r_a) begin
                        n_k = '0; n_state = S_ERD;
                    end else begin
                        par_re = 1'b1; par_ra = r_b[NW-1:0];
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                // Follow parents back from the destination, storing each hop.
                path_we = 1'b1; path_wa = r_len[NW-1:0]; path_wd = r_par_rd;
                n_len = r_len + 1'b1;
                if (r_par_rd == r_a) begin
                    n_k = r_len[NW-1:0];
                    n_state = S_ERD;
                end else begin
                    par_re = 1'b1; par_ra = r_par_rd[NW-1:0];
                end
            end
            S_ERD: begin
                path_re = 1'b1; path_ra = r_k;
                n_state = S_EOUT;
            end
            S_EOUT: begin
                if (can_push) begin
                    n_ovalid = 1'b1; n_opath = r_path_rd;
                    n_olast = (r_k == '0); n_ostat = ST_OK;
                    if (r_k == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k = r_k - 1'b1;
                        n_state = S_ERD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_node_count <= NODE_COUNT_RST;
            r_edges_used <= '0;
            r_nonempty   <= '0;
            r_seen       <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_edges_used <= n_edges_used;
            r_nonempty   <= n_nonempty;
            r_seen       <= n_seen;
            r_ovalid     <= n_ovalid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_node_count <= i_cfg.node_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a;  r_b <= n_b;  r_node <= n_node;
        r_qhead <= n_qhead;  r_qtail <= n_qtail;  r_len <= n_len;  r_k <= n_k;
        r_e <= n_e;  r_etail <= n_etail;  r_rstat <= n_rstat;
        r_opath <= n_opath;  r_olast <= n_olast;  r_ostat <= n_ostat;
    end

    always_ff @(posedge i_clk) begin
        if (edge_we) mem_tgt[edge_wa] <= edge_wd;
        if (link_we) mem_link[link_wa] <= link_wd;
        if (edge_re) begin
            r_tgt_rd  <= mem_tgt[edge_ra];
            r_link_rd <= mem_link[edge_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (head_we) mem_head[ht_wa] <= head_wd;
        if (tail_we) mem_tail[ht_wa] <= tail_wd;
        if (ht_re) begin
            r_head_rd <= mem_head[ht_ra];
            r_tail_rd <= mem_tail[ht_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (par_we) mem_par[par_wa] <= par_wd;
        if (par_re) r_par_rd <= mem_par[par_ra];
    end

    always_ff @(posedge i_clk) begin
        if (q_we) mem_q[q_wa] <= q_wd;
        if (q_re) r_q_rd <= mem_q[q_ra];
    end

    always_ff @(posedge i_clk) begin
        if (path_we) mem_path[path_wa] <= path_wd;
        if (path_re) r_path_rd <= mem_path[path_ra];
    end

endmodule

// ----- src/bfs_checker.sv -----
// Port-level checker for the shortest path block and its bind.
module bfs_checker
    import bfs_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic [MODE_W-1:0] in_mode,
    input logic              out_valid,
    input logic              out_ready,
    input logic [NODE_W-1:0] out_path_node,
    input logic              out_last,
    input logic [STAT_W-1:0] out_status
);

    // A held result beat keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_path_node)
            && $stable(out_last) && $stable(out_status))
        else $error("result beat changed while stalled");

    // An error status always ends the item and carries no node.
    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_status != ST_OK |-> out_last && out_path_node == '0)
        else $error("error status on a non-final or node-carrying beat");

    // Any real command makes the block busy on the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready && in_mode != MODE_UNUSED |=> !in_ready)
        else $error("block took a second item without working on the first");

    // Reset leaves no result pending.
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("result beat present after reset");

endmodule

bind bfs_shortest_path bfs_checker u_bfs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .in_valid      (i_in.valid),
    .in_ready      (i_in.ready),
    .in_mode       (i_in.mode),
    .out_valid     (o_out.valid),
    .out_ready     (o_out.ready),
    .out_path_node (o_out.path_node),
    .out_last      (o_out.last),
    .out_status    (o_out.status)
);
